// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/hcl_pkg.sv -----
`default_nettype none
package hcl_pkg;

   localparam int ByteWidth  = 8;
   localparam int CsrIdxWidth = 8;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_HEADER_FIRST  = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_HEADER_SECOND = 8'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HEADER_THIRD  = 8'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_LENGTH    = 8'd3;

   // Register reset values
   localparam logic [ByteWidth-1:0] HEADER_FIRST_RST  = 8'h52;
   localparam logic [ByteWidth-1:0] HEADER_SECOND_RST = 8'h4F;
   localparam logic [ByteWidth-1:0] HEADER_THIRD_RST  = 8'h59;
   localparam logic [ByteWidth-1:0] MAX_LENGTH_RST    = 8'd64;

   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_COMMAND,
      PHASE_LENGTH,
      PHASE_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] header_first;
      logic [ByteWidth-1:0] header_second;
      logic [ByteWidth-1:0] header_third;
      logic [ByteWidth-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] command;
      logic [ByteWidth-1:0] packet_length;
      logic [ByteWidth-1:0] data_byte;
      logic [ByteWidth-1:0] byte_index;
      logic                 has_data;
      logic                 last;
   } result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/hcl_csr.sv -----
`default_nettype none
module hcl_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [hcl_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [hcl_pkg::ByteWidth-1:0]   csr_data,
   output hcl_pkg::cfg_type                     cfg
);

   hcl_pkg::cfg_type cfg_ff;
   hcl_pkg::cfg_type cfg_in;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hcl_pkg::CSR_HEADER_FIRST:  cfg_in.header_first  = csr_data;
            hcl_pkg::CSR_HEADER_SECOND: cfg_in.header_second = csr_data;
            hcl_pkg::CSR_HEADER_THIRD:  cfg_in.header_third  = csr_data;
            hcl_pkg::CSR_MAX_LENGTH:    cfg_in.max_length    = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= hcl_pkg::HEADER_FIRST_RST;
         cfg_ff.header_second <= hcl_pkg::HEADER_SECOND_RST;
         cfg_ff.header_third  <= hcl_pkg::HEADER_THIRD_RST;
         cfg_ff.max_length    <= hcl_pkg::MAX_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/hcl_in_stage.sv -----
`default_nettype none
module hcl_in_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [hcl_pkg::ByteWidth-1:0] req_rx_byte,
   input  wire logic                          take,
   output logic                               req_stall,
   output logic                               item_valid,
   output logic [hcl_pkg::ByteWidth-1:0]      item_byte
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [hcl_pkg::ByteWidth-1:0] byte_ff;
   logic                         accept;

   // Slot is free when empty or when its item moves on this cycle
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/hcl_parse.sv -----
`default_nettype none
module hcl_parse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire logic [hcl_pkg::ByteWidth-1:0] item_byte,
   input  wire logic                          out_free,
   input  wire hcl_pkg::cfg_type              cfg,
   output logic                               take,
   output logic                               res_valid,
   output hcl_pkg::result_type                res
);

   hcl_pkg::phase_type            phase_ff, phase_in;
   logic [hcl_pkg::ByteWidth-1:0] prev_ff, prev_in;
   logic [hcl_pkg::ByteWidth-1:0] prev2_ff, prev2_in;
   logic [hcl_pkg::ByteWidth-1:0] cmd_ff, cmd_in;
   logic [hcl_pkg::ByteWidth-1:0] len_ff, len_in;
   logic [hcl_pkg::ByteWidth-1:0] pos_ff, pos_in;
   logic                          produces;
   logic                          fin;
   logic [hcl_pkg::ByteWidth:0]   pos_next;

   assign pos_next = {1'b0, pos_ff} + 9'd1;
   assign fin      = pos_next >= {1'b0, len_ff};

   // Does the pending byte yield a result
   always_comb begin
      unique case (phase_ff)
         hcl_pkg::PHASE_LENGTH:  produces = (item_byte == '0);
         hcl_pkg::PHASE_PAYLOAD: produces = 1'b1;
         default:                produces = 1'b0;
      endcase
   end

   assign take      = item_valid && (out_free || !produces);
   assign res_valid = take && produces;

   // Phase update and result formation
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      res      = '0;
      res.command = cmd_ff;
      if (take) begin
         prev2_in = prev_ff;
         prev_in  = item_byte;
         unique case (phase_ff)
            hcl_pkg::PHASE_HUNT: begin
               if (item_byte == cfg.header_third && prev_ff == cfg.header_second &&
                   prev2_ff == cfg.header_first) begin
                  phase_in = hcl_pkg::PHASE_COMMAND;
               end
            end
            hcl_pkg::PHASE_COMMAND: begin
               cmd_in   = item_byte;
               phase_in = hcl_pkg::PHASE_LENGTH;
            end
            hcl_pkg::PHASE_LENGTH: begin
               if (item_byte == '0) begin
                  // empty packet: one result with last set
                  res.last = 1'b1;
                  phase_in = hcl_pkg::PHASE_HUNT;
                  cmd_in   = '0;
                  len_in   = '0;
                  pos_in   = '0;
               end else if (item_byte > cfg.max_length) begin
                  // too long: drop the frame
                  phase_in = hcl_pkg::PHASE_HUNT;
                  cmd_in   = '0;
                  len_in   = '0;
                  pos_in   = '0;
               end else begin
                  len_in   = item_byte;
                  pos_in   = '0;
                  phase_in = hcl_pkg::PHASE_PAYLOAD;
               end
            end
            hcl_pkg::PHASE_PAYLOAD: begin
               res.packet_length  = len_ff;
               res.data_byte      = item_byte;
               res.byte_index     = pos_ff;
               res.has_data       = 1'b1;
               res.last           = fin;
               if (fin) begin
                  phase_in = hcl_pkg::PHASE_HUNT;
                  cmd_in   = '0;
                  len_in   = '0;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_next[hcl_pkg::ByteWidth-1:0];
               end
            end
            default: phase_in = hcl_pkg::PHASE_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hcl_pkg::PHASE_HUNT;
         prev_ff  <= '0;
         prev2_ff <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/hcl_out_reg.sv -----
`default_nettype none
module hcl_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                res_valid,
   input  wire hcl_pkg::result_type res,
   input  wire logic                rsp_stall,
   output logic                     out_free,
   output logic                     rsp_valid,
   output hcl_pkg::result_type      rsp
);

   logic                valid_ff;
   hcl_pkg::result_type res_ff;

   // Register can load when empty or drained this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/header_command_length_deframer.sv -----
// Packet deframer for a byte stream: hunts for a configurable three-byte sync header,
// then reads a command byte and a length byte, and streams each payload byte out as
// one result carrying command, length, index and a last mark on the final byte; a
// zero length gives a single empty result with last set, and a length above max_length
// drops the frame silently. One byte is taken every clock cycle while the result side
// keeps up; a byte goes from its input register through the parser into the result
// register, from which its result is offered to the receiver. Registers are
// written over the csr port (index 0..3: header_first, header_second, header_third,
// max_length); other indexes are ignored and csr_ready is always high.
`default_nettype none
module header_command_length_deframer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // byte input
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [hcl_pkg::ByteWidth-1:0]   req_rx_byte,
   // results
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [hcl_pkg::ByteWidth-1:0]        rsp_command,
   output logic [hcl_pkg::ByteWidth-1:0]        rsp_packet_length,
   output logic [hcl_pkg::ByteWidth-1:0]        rsp_data_byte,
   output logic [hcl_pkg::ByteWidth-1:0]        rsp_byte_index,
   output logic                                 rsp_has_data,
   output logic                                 rsp_last,
   // configuration
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hcl_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [hcl_pkg::ByteWidth-1:0]   csr_data
);

   hcl_pkg::cfg_type              cfg;
   hcl_pkg::result_type           res;
   hcl_pkg::result_type           rsp;
   logic                          item_valid;
   logic [hcl_pkg::ByteWidth-1:0] item_byte;
   logic                          take;
   logic                          res_valid;
   logic                          out_free;

   assign csr_ready = 1'b1;

   hcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hcl_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .req_stall   (req_stall),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   hcl_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .out_free   (out_free),
      .cfg        (cfg),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   hcl_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_command        = rsp.command;
   assign rsp_packet_length  = rsp.packet_length;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_byte_index     = rsp.byte_index;
   assign rsp_has_data       = rsp.has_data;
   assign rsp_last           = rsp.last;

endmodule
`default_nettype wire

// ----- hw/rtl/hcl_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module hcl_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic [hcl_pkg::ByteWidth-1:0]   req_rx_byte,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [hcl_pkg::ByteWidth-1:0]   rsp_command,
   input wire logic [hcl_pkg::ByteWidth-1:0]   rsp_packet_length,
   input wire logic [hcl_pkg::ByteWidth-1:0]   rsp_data_byte,
   input wire logic [hcl_pkg::ByteWidth-1:0]   rsp_byte_index,
   input wire logic                            rsp_has_data,
   input wire logic                            rsp_last
);

   // An empty packet result is a bare last mark
   `ASSERT_IMPLY(a_empty_result, clock, reset, rsp_valid && !rsp_has_data,
      rsp_last && rsp_packet_length == '0 && rsp_data_byte == '0 && rsp_byte_index == '0,
      "empty result malformed")

   // Payload index stays inside the declared length
   `ASSERT_IMPLY(a_index_range, clock, reset, rsp_valid && rsp_has_data,
      rsp_byte_index < rsp_packet_length, "byte index out of range")

   // Last mark falls exactly on the final payload byte
   `ASSERT_IMPLY(a_last_position, clock, reset, rsp_valid && rsp_has_data,
      rsp_last == ({1'b0, rsp_byte_index} + 9'd1 == {1'b0, rsp_packet_length}),
      "last mark misplaced")

   // A stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_command) && $stable(rsp_packet_length) &&
      $stable(rsp_data_byte) && $stable(rsp_byte_index) && $stable(rsp_has_data) &&
      $stable(rsp_last), "stalled result changed")

   // A stalled input item holds
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_rx_byte), "stalled input item changed")

endmodule

bind header_command_length_deframer hcl_checker u_hcl_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Indexes past the register list; writes there must be dropped
   localparam logic [hcl_pkg::CsrIdxWidth-1:0] CSR_FIRST_UNUSED = 8'd4;
   localparam logic [hcl_pkg::CsrIdxWidth-1:0] CSR_LAST_UNUSED  = 8'hFF;

   // Tracks parser state and holds the results still owed by the block
   class deframe_scoreboard;
      hcl_pkg::cfg_type    regs;
      hcl_pkg::phase_type  phase;
      logic [7:0]          prev_byte;
      logic [7:0]          prev2_byte;
      logic [7:0]          cmd;
      logic [7:0]          len;
      logic [7:0]          pos;
      hcl_pkg::result_type owed[$];
      int                  errors;

      function new();
         regs = '{hcl_pkg::HEADER_FIRST_RST, hcl_pkg::HEADER_SECOND_RST,
                  hcl_pkg::HEADER_THIRD_RST, hcl_pkg::MAX_LENGTH_RST};
         phase = hcl_pkg::PHASE_HUNT;
         prev_byte = '0;
         prev2_byte = '0;
         cmd = '0;
         len = '0;
         pos = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [hcl_pkg::CsrIdxWidth-1:0] idx, logic [7:0] value);
         case (idx)
            hcl_pkg::CSR_HEADER_FIRST: begin
               regs.header_first = value;
            end
            hcl_pkg::CSR_HEADER_SECOND: begin
               regs.header_second = value;
            end
            hcl_pkg::CSR_HEADER_THIRD: begin
               regs.header_third = value;
            end
            hcl_pkg::CSR_MAX_LENGTH: begin
               regs.max_length = value;
            end
            default: ;
         endcase
      endfunction

      function void close_frame();
         phase = hcl_pkg::PHASE_HUNT;
         cmd = '0;
         len = '0;
         pos = '0;
      endfunction

      // One accepted rx byte; queues the result it causes, if any
      function void note_byte(logic [7:0] b);
         hcl_pkg::result_type r;
         logic [8:0]          next_pos;
         case (phase)
            hcl_pkg::PHASE_HUNT: begin
               if (b == regs.header_third && prev_byte == regs.header_second &&
                   prev2_byte == regs.header_first)
                  phase = hcl_pkg::PHASE_COMMAND;
            end
            hcl_pkg::PHASE_COMMAND: begin
               cmd = b;
               phase = hcl_pkg::PHASE_LENGTH;
            end
            hcl_pkg::PHASE_LENGTH: begin
               if (b == 8'd0) begin
                  r = '{cmd, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};
                  owed.push_back(r);
                  close_frame();
               end else if (b > regs.max_length) begin
                  close_frame();
               end else begin
                  len = b;
                  pos = '0;
                  phase = hcl_pkg::PHASE_PAYLOAD;
               end
            end
            default: begin
               next_pos = {1'b0, pos} + 9'd1;
               r = '{cmd, len, b, pos, 1'b1, next_pos >= {1'b0, len}};
               owed.push_back(r);
               if (r.last)
                  close_frame();
               else
                  pos = next_pos[7:0];
            end
         endcase
         prev2_byte = prev_byte;
         prev_byte = b;
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      // One accepted result, compared with the oldest owed one
      function void check_result(hcl_pkg::result_type got);
         hcl_pkg::result_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %p", $time, got);
            return;
         end
         want = owed.pop_front();
         check_field("command", want.command, got.command);
         check_field("packet_length", want.packet_length, got.packet_length);
         check_field("data_byte", want.data_byte, got.data_byte);
         check_field("byte_index", want.byte_index, got.byte_index);
         check_field("has_data", {7'd0, want.has_data}, {7'd0, got.has_data});
         check_field("last", {7'd0, want.last}, {7'd0, got.last});
      endfunction
   endclass

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [hcl_pkg::ByteWidth-1:0]   req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [hcl_pkg::ByteWidth-1:0]   rsp_command;
   logic [hcl_pkg::ByteWidth-1:0]   rsp_packet_length;
   logic [hcl_pkg::ByteWidth-1:0]   rsp_data_byte;
   logic [hcl_pkg::ByteWidth-1:0]   rsp_byte_index;
   logic                            rsp_has_data;
   logic                            rsp_last;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [hcl_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [hcl_pkg::ByteWidth-1:0]   csr_data = '0;

   int send_idle_pct = 14;
   int recv_idle_pct = 48;

   deframe_scoreboard sb = new();

   header_command_length_deframer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_command        (rsp_command),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_has_data       (rsp_has_data),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stall, check every accepted item
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_command, rsp_packet_length, rsp_data_byte,
                           rsp_byte_index, rsp_has_data, rsp_last});
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Offer one byte, with random gaps ahead of it, and hold it until taken
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(value);
   endtask

   // Stop sending until every owed result is back, plus the pipeline depth
   task automatic wait_results();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [hcl_pkg::CsrIdxWidth-1:0] idx,
                            input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [7:0] h3, input logic [7:0] max_len);
      write_csr(hcl_pkg::CSR_HEADER_FIRST, h1);
      write_csr(hcl_pkg::CSR_HEADER_SECOND, h2);
      write_csr(hcl_pkg::CSR_HEADER_THIRD, h3);
      write_csr(hcl_pkg::CSR_MAX_LENGTH, max_len);
   endtask

   // Mostly well-formed frames under the current header, plus broken ones and noise
   task automatic random_traffic(input int n_items);
      int         sent;
      int         kind;
      int         short_max;
      int         n;
      logic [7:0] frame_len;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            send_byte(sb.regs.header_first);
            send_byte(sb.regs.header_second);
            send_byte(sb.regs.header_third);
            send_byte(8'($urandom));
            short_max = (sb.regs.max_length < 8) ? sb.regs.max_length : 8;
            n = $urandom_range(9);
            if (n == 0 || sb.regs.max_length == 0)
               frame_len = 8'd0;
            else if (n == 1 && sb.regs.max_length != 8'hFF)
               frame_len = 8'($urandom_range(255, sb.regs.max_length + 1));
            else if ($urandom_range(19) == 0)
               frame_len = 8'($urandom_range(sb.regs.max_length, 1));
            else
               frame_len = 8'($urandom_range(short_max, 1));
            send_byte(frame_len);
            sent += 5;
            if (frame_len <= sb.regs.max_length) begin
               for (int i = 0; i < frame_len; i++)
                  send_byte(8'($urandom));
               sent += frame_len;
            end
         end else if (kind < 85) begin
            // header cut short, then a stray byte
            send_byte(sb.regs.header_first);
            if ($urandom_range(1)) begin
               send_byte(sb.regs.header_second);
               sent++;
            end
            send_byte(8'($urandom));
            sent += 2;
         end else begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
               send_byte(8'($urandom));
            sent += n;
         end
         if ($urandom_range(63) == 0)
            wait_results();
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = '{
         // empty packet, zero command
         8'h52, 8'h4F, 8'h59, 8'h00, 8'h00,
         // two-byte payload that ends on the first two header bytes
         8'h52, 8'h4F, 8'h59, 8'hFF, 8'h02, 8'h52, 8'h4F,
         // header completed across the frame end; length over the limit drops it
         8'h59, 8'hAA, 8'h41,
         // frame left open mid-payload across the register change
         8'h52, 8'h4F, 8'h59, 8'h5A, 8'h03, 8'hFF, 8'h00
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset values
      foreach (directed[i])
         send_byte(directed[i]);
      wait_results();

      // Shrinking the limit mid-payload must not cut the open frame short
      write_csr(hcl_pkg::CSR_MAX_LENGTH, 8'd1);
      send_byte(8'h80);
      random_traffic(140);
      wait_results();

      // All-zero header, widest limit
      write_all(8'h00, 8'h00, 8'h00, 8'hFF);
      random_traffic(170);
      wait_results();

      // Swap the idle rates; all-ones header and a zero limit
      send_idle_pct = 48;
      recv_idle_pct = 14;
      write_all(8'hFF, 8'hFF, 8'hFF, 8'h00);
      random_traffic(100);
      wait_results();

      // Random header and limit; writes past the register list are ignored
      write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)));
      write_csr(CSR_FIRST_UNUSED, 8'($urandom));
      write_csr(CSR_LAST_UNUSED, 8'($urandom));
      random_traffic(200);
      wait_results();

      // No idling from here on
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_all(hcl_pkg::HEADER_FIRST_RST, hcl_pkg::HEADER_SECOND_RST,
                hcl_pkg::HEADER_THIRD_RST, hcl_pkg::MAX_LENGTH_RST);
      random_traffic(180);
      wait_results();

      write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)));
      random_traffic(140);
      wait_results();
      repeat (10) @(posedge clock);

      if (sb.owed.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d results expected, 0 received", $time, sb.owed.size());
      end
      if (sb.errors == 0)
         $display("header_command_length_deframer: match");
      else
         $display("header_command_length_deframer: mismatch");
      $finish;
   end

   // Hang guard
   initial begin
      #2ms;
      $display("header_command_length_deframer: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
